@@ rtl/fmh_pkg.sv @@
// Shared types and codes for the FIFO hand-off mutex block.
package fmh_pkg;

  // Width of a requester number on the request channel.
  localparam int unsigned REQ_W = 4;

  // Largest number of requesters that the requester field can name.
  localparam int unsigned REQ_SPACE = 1 << REQ_W;

  typedef logic [REQ_W-1:0] requester_t;

  // Operation codes carried by a request transaction.
  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_TRYLOCK = 2'd1,
    OP_UNLOCK  = 2'd2,
    OP_CANCEL  = 2'd3
  } op_t;

  // Result codes carried by a response transaction.
  typedef enum logic [2:0] {
    ST_DONE            = 3'd0,
    ST_QUEUED          = 3'd1,
    ST_BUSY            = 3'd2,
    ST_DEADLOCK        = 3'd3,
    ST_NOT_OWNER       = 3'd4,
    ST_ALREADY_WAITING = 3'd5,
    ST_NOT_WAITING     = 3'd6
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the request transaction
    logic execute;  // apply the request and load the response register
  } fmh_cmd_t;

endpackage

@@ rtl/fmh_ctrl.sv @@
// Controller state machine: sequences capture and execution of each request.
module fmh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output fmh_pkg::fmh_cmd_t cmd
);
  import fmh_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // A request is taken only in the idle state.
  assign req_stall = (state != S_IDLE);

  // Execution waits until the response register is free or being emptied.
  assign cmd.capture = (state == S_IDLE) && req_valid;
  assign cmd.execute = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // State and the registered response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.execute) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.execute) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/fmh_datapath.sv @@
// Datapath: owner registers, waiter flags, shift queue of waiters and response register.
module fmh_datapath #(
  parameter int unsigned REQUESTERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  fmh_pkg::fmh_cmd_t   cmd,
  input  logic [1:0]          op,
  input  fmh_pkg::requester_t requester,
  output logic [2:0]          status,
  output logic                wake_valid,
  output fmh_pkg::requester_t woken_requester,
  output logic                locked_now,
  output fmh_pkg::requester_t current_owner
);
  import fmh_pkg::*;

  // Only requesters that the field can name are ever stored.
  localparam int unsigned NREQ   = (REQUESTERS < REQ_SPACE) ? REQUESTERS : REQ_SPACE;
  localparam int unsigned QDEPTH = NREQ;
  localparam int unsigned IDXW   = $clog2(NREQ);
  localparam int unsigned CW     = $clog2(QDEPTH + 1);
  localparam logic [REQ_W:0] NREQ_V = (REQ_W + 1)'(NREQ);
  localparam logic [CW-1:0]  QFULL  = CW'(QDEPTH);

  // Captured request transaction.
  op_t        op_r;
  requester_t req_r;

  // Mutex state.
  logic            held, held_next;
  requester_t      holder, holder_next;
  logic [CW-1:0]   count, count_next;
  logic [NREQ-1:0] flags, flags_next;
  requester_t      q [QDEPTH];
  requester_t      q_next [QDEPTH];

  // Step decode.
  logic              in_range;
  logic              flag_hit;
  logic [IDXW-1:0]   req_idx;
  logic [IDXW-1:0]   head_idx;
  logic [QDEPTH-1:0] match;
  logic [QDEPTH-1:0] rm;
  logic [QDEPTH-1:0] shift_en;
  logic              do_append;
  status_t           st;
  logic              wake;
  requester_t        woken;

  // Capture the request when the controller takes it.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(op);
      req_r <= requester;
    end
  end

  // Cells holding the waiter named in the request, within the filled part.
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      match[i] = (CW'(i) < count) && (q[i] == req_r);
    end
  end

  assign in_range = {1'b0, req_r} < NREQ_V;
  assign req_idx  = req_r[IDXW-1:0];
  assign head_idx = q[0][IDXW-1:0];
  assign flag_hit = in_range && flags[req_idx];

  // Next state of owner, count, flags and the removal mask.
  always_comb begin
    held_next   = held;
    holder_next = holder;
    count_next  = count;
    flags_next  = flags;
    rm          = '0;
    do_append   = 1'b0;
    st          = ST_DONE;
    wake        = 1'b0;
    woken       = '0;
    unique case (op_r)
      OP_LOCK: begin
        priority if (!in_range) begin
          st = ST_BUSY;
        end else if (!held) begin
          held_next   = 1'b1;
          holder_next = req_r;
        end else if (holder == req_r) begin
          st = ST_DEADLOCK;
        end else if (flag_hit) begin
          st = ST_ALREADY_WAITING;
        end else if (count < QFULL) begin
          do_append           = 1'b1;
          count_next          = count + CW'(1);
          flags_next[req_idx] = 1'b1;
          st                  = ST_QUEUED;
        end else begin
          st = ST_BUSY;
        end
      end
      OP_TRYLOCK: begin
        priority if (!in_range) begin
          st = ST_BUSY;
        end else if (held) begin
          st = (holder == req_r) ? ST_DEADLOCK : ST_BUSY;
        end else begin
          held_next   = 1'b1;
          holder_next = req_r;
        end
      end
      OP_UNLOCK: begin
        priority if (!held || holder != req_r) begin
          st = ST_NOT_OWNER;
        end else if (count == '0) begin
          held_next   = 1'b0;
          holder_next = '0;
        end else begin
          woken                = q[0];
          wake                 = 1'b1;
          holder_next          = q[0];
          rm[0]                = 1'b1;
          count_next           = count - CW'(1);
          flags_next[head_idx] = 1'b0;
        end
      end
      OP_CANCEL: begin
        if (!flag_hit) begin
          st = ST_NOT_WAITING;
        end else begin
          rm                  = match;
          count_next          = count - CW'(1);
          flags_next[req_idx] = 1'b0;
        end
      end
      default: begin
        st = ST_DONE;
      end
    endcase
  end

  // Each cell moves up by one when a removal happened at or below it.
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      shift_en[i] = 1'b0;
      for (int j = 0; j <= i; j++) begin
        shift_en[i] = shift_en[i] | rm[j];
      end
    end
  end

  // Queue cells: shift on removal, write the tail cell on append.
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    for (int i = 0; i < QDEPTH - 1; i++) begin
      if (shift_en[i]) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (do_append && (count == CW'(i))) begin
        q_next[i] = req_r;
      end
    end
  end

  // Mutex state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      holder <= '0;
      count  <= '0;
      flags  <= '0;
    end else if (cmd.execute) begin
      held   <= held_next;
      holder <= holder_next;
      count  <= count_next;
      flags  <= flags_next;
    end
  end

  // Queue cells carry no reset; entries beyond the count are never read.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < QDEPTH; i++) begin
        q[i] <= q_next[i];
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      status          <= st;
      wake_valid      <= wake;
      woken_requester <= woken;
      locked_now      <= held_next;
      current_owner   <= held_next ? holder_next : '0;
    end
  end

endmodule

@@ rtl/fifo_handoff_mutex.sv @@
// Top level of the FIFO hand-off mutex: controller plus datapath.
//
// Lock unit for one mutex shared by numbered requesters, with a first-in
// first-out queue of waiters. A request transaction (op, requester) arrives
// on req_valid/req_stall; each one produces exactly one response transaction
// (status, wake_valid, woken_requester, locked_now, current_owner) on
// rsp_valid/rsp_stall.
//
// A request is captured when it is taken and applied in the execute state
// once the response register is free or being emptied, which loads the
// response. The unit takes no new request until the last one is applied,
// as set by the capture and execute steps of the controller. The whole
// queue update (append, head removal or removal from any position) is
// done in the execute step by per-cell compare and shift.
//
// While a response is stalled the unit still accepts the next request and
// holds it; execution of that request waits until the response register is
// taken. Synchronous reset frees the mutex, empties the queue and clears all
// waiter flags; no clearing pass is needed.
module fifo_handoff_mutex #(
  parameter int unsigned REQUESTERS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          op,
  input  fmh_pkg::requester_t requester,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [2:0]          status,
  output logic                wake_valid,
  output fmh_pkg::requester_t woken_requester,
  output logic                locked_now,
  output fmh_pkg::requester_t current_owner
);
  import fmh_pkg::*;

  fmh_cmd_t cmd;

  // Sequencing of request and response transactions.
  fmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // Owner, queue and response storage.
  fmh_datapath #(
    .REQUESTERS (REQUESTERS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .op              (op),
    .requester       (requester),
    .status          (status),
    .wake_valid      (wake_valid),
    .woken_requester (woken_requester),
    .locked_now      (locked_now),
    .current_owner   (current_owner)
  );

endmodule

@@ rtl/fmh_checker.sv @@
// Port-level checker for the FIFO hand-off mutex, bound to the top level.
module fmh_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input logic [2:0]          status,
  input logic                wake_valid,
  input fmh_pkg::requester_t woken_requester,
  input logic                locked_now,
  input fmh_pkg::requester_t current_owner
);
  import fmh_pkg::*;

  // A stalled response transaction keeps its valid and its status.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status))
    else $error("stalled response changed");

  // A request is never taken in the cycle right after another one.
  a_req_spacing: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken in consecutive cycles");

  // A hand-off makes the woken waiter the owner.
  a_wake_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && wake_valid |->
      locked_now && (current_owner == woken_requester) && (status == ST_DONE))
    else $error("hand-off does not match new owner");

  // A free mutex reports no owner.
  a_free_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !locked_now |-> (current_owner == '0) && !wake_valid)
    else $error("free mutex reports an owner");

endmodule

bind fifo_handoff_mutex fmh_checker u_fmh_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req_valid),
  .req_stall       (req_stall),
  .rsp_valid       (rsp_valid),
  .rsp_stall       (rsp_stall),
  .status          (status),
  .wake_valid      (wake_valid),
  .woken_requester (woken_requester),
  .locked_now      (locked_now),
  .current_owner   (current_owner)
);
